// File: rtl/core/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

    localparam logic [1:0] MODE_ABSORB = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // buffer write source
    localparam logic [1:0] WSEL_DATA = 2'd0;
    localparam logic [1:0] WSEL_PAD = 2'd1;
    localparam logic [1:0] WSEL_ZERO = 2'd2;
    localparam logic [1:0] WSEL_LEN = 2'd3;

    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       count_byte;
        logic       comp_start;
        logic       chain_reset;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       comp_busy;
    } sha_status_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

// File: rtl/core/sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps
// channel  signals                          beat
// in       valid/ready, mode, data_byte     one byte and mode
// out      out_valid/out_ready, digest_*    256-bit digest
// One byte per cycle while ready is high; the 64th byte of a block starts a
// compression that holds ready low (load, 64 rounds, chain add), so no byte
// is taken while it runs. Finish holds ready low for the padding writes, one
// or two compressions and the digest load. A waiting digest stalls only the
// next finish. Reset loads the initial hash values.
module sha256_byte_stream_hasher_top
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_high,
    output logic [63:0] digest_mid_high,
    output logic [63:0] digest_mid_low,
    output logic [63:0] digest_low
);

    sha_cmd_t     cmd;
    sha_status_t  status;
    logic         out_load;
    logic [255:0] digest;

    sha256_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready), .mode(mode),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .cmd(cmd), .out_load(out_load)
    );

    sha256_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(data_byte),
        .out_load(out_load), .status(status), .digest(digest)
    );

    assign digest_high = digest[255:192];
    assign digest_mid_high = digest[191:128];
    assign digest_mid_low = digest[127:64];
    assign digest_low = digest[63:0];

endmodule

// File: rtl/core/sha256_ctrl.sv
`timescale 1ns / 1ps
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  mode,
    output logic        out_valid,
    input  logic        out_ready,
    input  sha_status_t status,
    output sha_cmd_t    cmd,
    output logic        out_load
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_PAD = 3'd2;
    localparam logic [2:0] ST_ZFILL = 3'd3;
    localparam logic [2:0] ST_LEN = 3'd4;
    localparam logic [2:0] ST_FWAIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    logic comp_idle;
    assign comp_idle = !status.comp_busy;
    assign out_valid = ov_reg;
    assign ready = (state_reg == ST_IDLE) && comp_idle;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg;
        cmd = '0;
        out_load = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (valid && ready && mode != MODE_UNUSED)
                begin
                    if (mode inside {MODE_ABSORB, MODE_ABSORB_FINISH})
                    begin
                        cmd.wr_en = 1'b1;
                        cmd.wr_sel = WSEL_DATA;
                        cmd.count_byte = 1'b1;
                        if (status.fill == 6'd63)
                        begin
                            cmd.comp_start = 1'b1;
                        end
                    end
                    if (mode != MODE_ABSORB)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (comp_idle)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = WSEL_PAD;
                if (status.fill == 6'd63)
                begin
                    cmd.comp_start = 1'b1;
                    state_next = ST_ZFILL;
                end
                else
                begin
                    state_next = ST_ZFILL;
                end
            end
            ST_ZFILL:
            begin
                if (comp_idle)
                begin
                    if (status.fill == 6'd56)
                    begin
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                        cmd.wr_sel = WSEL_ZERO;
                        if (status.fill == 6'd63)
                        begin
                            cmd.comp_start = 1'b1;
                        end
                    end
                end
            end
            ST_LEN:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel = WSEL_LEN;
                if (status.fill == 6'd63)
                begin
                    cmd.comp_start = 1'b1;
                    state_next = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                if (comp_idle && !ov_reg)
                begin
                    out_load = 1'b1;
                    cmd.chain_reset = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

endmodule

// File: rtl/core/sha256_dp.sv
`timescale 1ns / 1ps
module sha256_dp
    import sha256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sha_cmd_t     cmd,
    input  logic [7:0]   data_byte,
    input  logic         out_load,
    output sha_status_t  status,
    output logic [255:0] digest
);

    logic [5:0]  fill_reg;
    logic [63:0] total_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];   // block words, then the schedule window
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        load_reg;   // one-cycle strobe: copy chain into working vars
    logic        add_reg;    // one-cycle strobe: fold working vars into chain
    logic [255:0] dig_reg;

    logic [7:0]  wr_byte;
    logic [63:0] bits;
    logic [2:0]  len_idx;

    assign bits = {total_reg[60:0], 3'b000};
    assign len_idx = fill_reg[2:0];

    always_comb
    begin
        case (cmd.wr_sel)
            WSEL_DATA: wr_byte = data_byte;
            WSEL_PAD:  wr_byte = 8'h80;
            WSEL_ZERO: wr_byte = 8'h00;
            WSEL_LEN:  wr_byte = bits[{~len_idx, 3'b000} +: 8];
            default:   wr_byte = 8'h00;
        endcase
    end

    assign status.fill = fill_reg;
    assign status.comp_busy = busy_reg || load_reg || add_reg;
    assign digest = dig_reg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] s0, s1, w_new, t1, t2, ch, mj, wr_cur;
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        wr_cur = w_reg[0];
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
            + ch + ROUND_K[rnd_reg] + wr_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22)) + mj;
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (cmd.wr_en)
        begin
            // big-endian byte lanes
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
        if (out_load)
        begin
            dig_reg <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                        h_reg[4], h_reg[5], h_reg[6], h_reg[7]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            total_reg <= '0;
            rnd_reg <= '0;
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            add_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            if (cmd.chain_reset)
            begin
                fill_reg <= '0;
                total_reg <= '0;
            end
            else
            begin
                if (cmd.wr_en)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.count_byte)
                begin
                    total_reg <= total_reg + 64'd1;
                end
            end
            load_reg <= cmd.comp_start;
            add_reg <= busy_reg && (rnd_reg == 6'd63);
            if (load_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (cmd.chain_reset)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= INIT_H[i];
                end
            end
            else if (add_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

endmodule
